>>> hw/rtl/color_keyed_alpha_overlay_macros.svh
// assertion macros for the colour-keyed overlay block
`ifndef COLOR_KEYED_ALPHA_OVERLAY_MACROS_SVH
`define COLOR_KEYED_ALPHA_OVERLAY_MACROS_SVH

// consequent in the cycle after the antecedent
`define CKAO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ckao check failed");

// consequent in the same cycle as the antecedent
`define CKAO_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ckao check failed");

`endif

>>> hw/rtl/ckao_pkg.sv
// shared types and constants for the colour-keyed overlay block
package ckao_pkg;

    localparam int PIX_W   = 8;
    localparam int SIZE_W  = 13;
    localparam int POS_W   = 14;
    localparam int ALPHA_W = 31;
    localparam int CNT_W   = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 31;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_ALPHA_FRAC_BITS = 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BG_WIDTH   = 3'd0,
        CFG_OVL_WIDTH  = 3'd1,
        CFG_OVL_HEIGHT = 3'd2,
        CFG_POS_X      = 3'd3,
        CFG_POS_Y      = 3'd4,
        CFG_KEY_VALUE  = 3'd5,
        CFG_ALPHA_BG   = 3'd6,
        CFG_ALPHA_OVL  = 3'd7
    } t_cfg_reg;

endpackage

>>> hw/rtl/color_keyed_alpha_overlay.sv
// colour-keyed alpha overlay on one byte plane, one background byte per beat
//
// input stream: one beat per background byte in raster order, tdata holds the
// background byte and the co-located overlay byte, tlast marks the last byte
// of the frame and returns the column and row counters to zero.
// output stream: one beat per input beat, in order; tdata is the resulting
// byte, tuser flags a position inside the clipped overlay window.
// config channel: index 0..7 selects bg_width, ovl_width, ovl_height, pos_x,
// pos_y, key_value, alpha_bg, alpha_ovl; always ready; the user must write it
// only while the stream is idle, the block itself does not enforce this.
// an accepted beat passes the window test into the input register and the
// blend into the output register before it is presented on the output.
// throughput: one beat per clock while the receiver does not stall; the
// blend is two 8x31 multipliers working side by side in the second stage.
// a receiver stall holds the output register; the input side keeps taking
// beats until the input register is also full, then drops tready.
// reset clears the counters, the pipeline valids and all config registers.
module color_keyed_alpha_overlay #(
    parameter int MAX_WIDTH       = ckao_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = ckao_pkg::DEF_MAX_HEIGHT,
    parameter int ALPHA_FRAC_BITS = ckao_pkg::DEF_ALPHA_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] bg_pixel, [15:8] ovl_pixel
    input  logic [2*ckao_pkg::PIX_W-1:0]       i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [7:0] out_pixel
    output logic [ckao_pkg::PIX_W-1:0]         o_m_axis_tdata,
    // [0] in_window
    output logic                               o_m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ckao_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ckao_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ckao_pkg::*;

    localparam logic [31:0] MAX_W_EVEN = 32'(MAX_WIDTH) & ~32'd1;
    localparam logic [31:0] MAX_H_EVEN = 32'(MAX_HEIGHT) & ~32'd1;
    localparam int PROD_W = PIX_W + ALPHA_W;
    localparam int DIFF_W = POS_W + 2;

    // configuration
    logic [SIZE_W-1:0]  r_bg_width, r_ovl_width, r_ovl_height;
    logic [POS_W-1:0]   r_pos_x, r_pos_y;
    logic [PIX_W-1:0]   r_key;
    logic [ALPHA_W-1:0] r_alpha_bg, r_alpha_ovl;

    // raster position
    logic [CNT_W-1:0]   r_col, r_row;
    logic [CNT_W-1:0]   n_col, n_row;

    // input register
    logic               r_s1_valid;
    logic [PIX_W-1:0]   r_s1_bg, r_s1_ov;
    logic               r_s1_inside;

    // output register
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_pixel;
    logic               r_out_inside;

    logic               acc, out_load;
    logic [SIZE_W-1:0]  bgw, ow, oh, bgw_raw, ow_raw, oh_raw;
    logic signed [DIFF_W-1:0] dx, dy;
    logic               win_hit;
    logic [CNT_W:0]     col_inc;
    logic [PROD_W-1:0]  prod_bg, prod_ov;
    logic [PROD_W:0]    blend_sum;
    logic [PIX_W-1:0]   n_out_pixel;
    t_cfg_reg           cfg_sel;

    assign o_cfg_ready = 1'b1;
    assign cfg_sel     = t_cfg_reg'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_width   <= '0;
            r_ovl_width  <= '0;
            r_ovl_height <= '0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_key        <= '0;
            r_alpha_bg   <= '0;
            r_alpha_ovl  <= '0;
        end else if (i_cfg_valid) begin
            unique case (cfg_sel)
                CFG_BG_WIDTH:   r_bg_width   <= i_cfg_data[SIZE_W-1:0];
                CFG_OVL_WIDTH:  r_ovl_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_OVL_HEIGHT: r_ovl_height <= i_cfg_data[SIZE_W-1:0];
                CFG_POS_X:      r_pos_x      <= i_cfg_data[POS_W-1:0];
                CFG_POS_Y:      r_pos_y      <= i_cfg_data[POS_W-1:0];
                CFG_KEY_VALUE:  r_key        <= i_cfg_data[PIX_W-1:0];
                CFG_ALPHA_BG:   r_alpha_bg   <= i_cfg_data[ALPHA_W-1:0];
                CFG_ALPHA_OVL:  r_alpha_ovl  <= i_cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes: even, capped at the maximum
    always_comb begin
        bgw_raw = r_bg_width & ~SIZE_W'(1);
        ow_raw  = r_ovl_width & ~SIZE_W'(1);
        oh_raw  = r_ovl_height & ~SIZE_W'(1);
        bgw = (32'(bgw_raw) > MAX_W_EVEN) ? MAX_W_EVEN[SIZE_W-1:0] : bgw_raw;
        ow  = (32'(ow_raw)  > MAX_W_EVEN) ? MAX_W_EVEN[SIZE_W-1:0] : ow_raw;
        oh  = (32'(oh_raw)  > MAX_H_EVEN) ? MAX_H_EVEN[SIZE_W-1:0] : oh_raw;
    end

    // window test on the current position
    always_comb begin
        dx = $signed(DIFF_W'(r_col)) - DIFF_W'(signed'(r_pos_x));
        dy = $signed(DIFF_W'(r_row)) - DIFF_W'(signed'(r_pos_y));
        win_hit = (r_col < bgw) && (dx >= 0) && (dx < $signed(DIFF_W'(ow)))
               && (dy >= 0) && (dy < $signed(DIFF_W'(oh)));
    end

    // handshake
    assign out_load        = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || out_load;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;

    // counter advance
    always_comb begin
        col_inc = {1'b0, r_col} + (CNT_W+1)'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (i_s_axis_tlast) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= {1'b0, bgw}) begin
            n_col = '0;
            n_row = r_row + CNT_W'(1);
        end else begin
            n_col = col_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_bg     <= i_s_axis_tdata[PIX_W-1:0];
            r_s1_ov     <= i_s_axis_tdata[2*PIX_W-1:PIX_W];
            r_s1_inside <= win_hit;
        end
    end

    // blend stage
    always_comb begin
        prod_bg   = PROD_W'(r_s1_bg) * PROD_W'(r_alpha_bg);
        prod_ov   = PROD_W'(r_s1_ov) * PROD_W'(r_alpha_ovl);
        blend_sum = (PROD_W+1)'(prod_bg >> ALPHA_FRAC_BITS)
                  + (PROD_W+1)'(prod_ov >> ALPHA_FRAC_BITS);
        n_out_pixel = r_s1_bg;
        if (r_s1_inside && (r_s1_ov != r_key)) begin
            if (r_alpha_bg == '0) begin
                n_out_pixel = r_s1_ov;
            end else if (r_alpha_ovl != '0) begin
                n_out_pixel = (blend_sum > (PROD_W+1)'(255)) ? PIX_W'(255)
                                                             : blend_sum[PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pixel  <= n_out_pixel;
            r_out_inside <= r_s1_inside;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_pixel;
    assign o_m_axis_tuser  = r_out_inside;

`include "color_keyed_alpha_overlay_macros.svh"

    `CKAO_ASSERT_NEXT(a_last_clears, acc && i_s_axis_tlast, (r_col == '0) && (r_row == '0))
    `CKAO_ASSERT_NEXT(a_zero_width_outside, acc && (bgw == '0), !r_s1_inside)
    `CKAO_ASSERT_NEXT(a_outside_passes, out_load && !r_s1_inside,
                      o_m_axis_tdata == $past(r_s1_bg))
    `CKAO_ASSERT_NEXT(a_key_passes, out_load && (r_s1_ov == r_key),
                      o_m_axis_tdata == $past(r_s1_bg))
    `CKAO_ASSERT_SAME(a_flag_vs_valid, r_s1_valid && !o_s_axis_tready, r_out_valid)

endmodule
